// ----- sv/tcw_pkg.sv -----
package tcw_pkg;

    // Field widths of the item ports.
    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int DEL_W     = 7;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_DELETE_CODE = 1'b0;

    // Default screen geometry.
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    // Character codes and reset values.
    localparam logic [CODE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CODE_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [DEL_W-1:0]  DEL_RESET  = 7'd127;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_COLOUR = 2'd3
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted word
        logic exec;      // apply the single-cycle part of the item
        logic cnt_clr;   // restart the sweep counter
        logic clr_step;  // write one blank cell of a clear sweep
        logic scr_step;  // one step of the scroll copy
        logic load_out;  // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic need_scroll;
        logic clr_last;
        logic scr_last;
    } t_status;

endpackage

// ----- sv/tcw_datapath.sv -----
module tcw_datapath #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_cmd                    i_cmd,
    output tcw_pkg::t_status                 o_status,
    input  logic [tcw_pkg::DEL_W-1:0]        i_del_code,
    input  logic [tcw_pkg::FUNC_W-1:0]       i_func,
    input  logic [tcw_pkg::CODE_W-1:0]       i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]      i_cell_index,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::ATTR_W-1:0]       o_attribute,
    output logic [tcw_pkg::CELL_W-1:0]       o_read_cell,
    output logic                             o_scrolled,
    output logic                             o_background_next
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int SCR_N = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam logic [CW:0]   COLS_L  = (CW + 1)'(COLS);
    localparam logic [RW:0]   ROWS_L  = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;

    t_func              r_func;
    logic [CODE_W-1:0]  r_code;
    logic [INDEX_W-1:0] r_cidx;

    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [ATTR_W-1:0]  r_attr;
    logic               r_fg;
    logic               r_scrolled;
    logic [CNTW-1:0]    r_cnt;

    logic [ROW_OUT_W-1:0] r_cursor_row;
    logic [COL_OUT_W-1:0] r_cursor_col;
    logic [ATTR_W-1:0]    r_attribute;
    logic [CELL_W-1:0]    r_read_cell;
    logic                 r_out_scrolled;
    logic                 r_background_next;

    // Put character result.
    logic [RW:0]        n_row_t;
    logic [CW:0]        n_col_t;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      n_col;
    logic [ATTR_W-1:0]  n_attr;
    logic               n_fg;
    logic               put_we;
    logic [CW-1:0]      put_col;
    logic [CODE_W-1:0]  put_char;
    logic               need_scroll;

    // Memory ports.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               rd_ok;

    always_comb begin
        n_row_t  = {1'b0, r_row};
        n_col_t  = {1'b0, r_col};
        n_attr   = r_attr;
        n_fg     = r_fg;
        put_we   = 1'b0;
        put_col  = r_col;
        put_char = r_code;
        if (r_code == CH_NEWLINE) begin
            n_row_t = n_row_t + (RW + 1)'(1);
            n_col_t = '0;
        end else if (r_code == CH_RETURN) begin
            n_col_t = '0;
        end else if (r_code[CODE_W-1]) begin
            // Colour escapes alternate between foreground and background.
            if (r_fg) begin
                n_attr = {r_code[3:0], r_attr[3:0]};
                n_fg   = 1'b0;
            end else begin
                n_attr = {r_attr[7:4], r_code[3:0]};
                n_fg   = 1'b1;
            end
        end else if (r_code[DEL_W-1:0] == i_del_code) begin
            if (r_col != '0) begin
                n_col_t  = n_col_t - (CW + 1)'(1);
                put_col  = r_col - CW'(1);
                put_char = CH_SPACE;
                put_we   = 1'b1;
            end
            n_fg = 1'b0;
        end else begin
            put_we  = 1'b1;
            n_col_t = n_col_t + (CW + 1)'(1);
            n_fg    = 1'b0;
        end
        if (n_col_t >= COLS_L) begin
            n_row_t = n_row_t + (RW + 1)'(1);
            n_col_t = '0;
        end
        need_scroll = (r_func == FUNC_PUT) && (n_row_t >= ROWS_L);
        n_row = (n_row_t >= ROWS_L) ? ROW_MAX : n_row_t[RW-1:0];
        n_col = n_col_t[CW-1:0];
    end

    assign rd_ok = (32'(r_cidx) < CELLS);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (i_cmd.exec && r_func == FUNC_PUT) begin
            mem_we    = put_we;
            mem_waddr = AW'(AW'(r_row) * AW'(COLS) + AW'(put_col));
            mem_wdata = {r_attr, put_char};
        end else if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt[AW-1:0];
            mem_wdata = {r_attr, CH_SPACE};
        end else if (i_cmd.scr_step && r_cnt != '0) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_cnt - CNTW'(1));
            mem_wdata = r_rdata;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (i_cmd.exec && r_func == FUNC_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(r_cidx);
        end else if (i_cmd.scr_step && r_cnt != CNTW'(SCR_N)) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(r_cnt + CNTW'(COLS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_code <= i_char_code;
            r_cidx <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_scrolled <= need_scroll;
        end
        if (i_cmd.load_out) begin
            r_cursor_row      <= ROW_OUT_W'(r_row);
            r_cursor_col      <= COL_OUT_W'(r_col);
            r_attribute       <= r_attr;
            r_read_cell       <= (r_func == FUNC_READ && rd_ok) ? r_rdata : '0;
            r_out_scrolled    <= r_scrolled;
            r_background_next <= r_fg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_attr <= ATTR_RESET;
            r_fg   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_func)
                    FUNC_PUT: begin
                        r_row  <= n_row;
                        r_col  <= n_col;
                        r_attr <= n_attr;
                        r_fg   <= n_fg;
                    end
                    FUNC_COLOUR: begin
                        r_attr <= r_code;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.scr_step) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    assign o_status.is_clear    = (r_func == FUNC_CLEAR);
    assign o_status.need_scroll = need_scroll;
    assign o_status.clr_last    = (r_cnt == CNTW'(CELLS - 1));
    assign o_status.scr_last    = (r_cnt == CNTW'(SCR_N));

    assign o_cursor_row      = r_cursor_row;
    assign o_cursor_col      = r_cursor_col;
    assign o_attribute       = r_attribute;
    assign o_read_cell       = r_read_cell;
    assign o_scrolled        = r_out_scrolled;
    assign o_background_next = r_background_next;

endmodule

// ----- sv/tcw_controller.sv -----
module tcw_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  tcw_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output tcw_pkg::t_cmd     o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_SCROLL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_status.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_status.need_scroll) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                o_cmd.scr_step = 1'b1;
                if (i_status.scr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/text_console_writer.sv -----
// A put, read or set-colour word is captured, executed and then loaded into the
// result register, which raises o_out_valid; a clear first sweeps every cell of the
// screen store, and a put that scrolls first copies the lower rows up by one.
// A stalled result register delays this further. A new word is taken only after
// the last result has been loaded; clear and scroll sweeps walk the screen store
// one cell per cycle.
// Reset: synchronous, active low; a clearing pass over all ROWS*COLS cells then
// fills the screen with white-on-black spaces while no input word is taken.
module text_console_writer #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input word channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]         i_func,
    input  logic [tcw_pkg::CODE_W-1:0]         i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]        i_cell_index,
    // Result word channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tcw_pkg::ROW_OUT_W-1:0]      o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]      o_cursor_col,
    output logic [tcw_pkg::ATTR_W-1:0]         o_attribute,
    output logic [tcw_pkg::CELL_W-1:0]         o_read_cell,
    output logic                               o_scrolled,
    output logic                               o_background_next,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tcw_pkg::*;

    // The delete code register lives here; the datapath only compares against it.
    logic [DEL_W-1:0] r_del_code;
    logic             reg_sel;
    t_cmd             cmd;
    t_status          status;

    // Registers are word aligned, so bit 2 of the byte address picks the register.
    assign reg_sel = (paddr[2] == REG_DELETE_CODE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DATA_W'(r_del_code) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_del_code <= DEL_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_del_code <= pwdata[DEL_W-1:0];
        end
    end

    // The controller sequences each item: capture, an execute step, an optional
    // sweep over the screen store, then loading of the result register.
    tcw_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The datapath owns the screen store, the cursor, the colour and the result.
    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_del_code        (r_del_code),
        .i_func            (i_func),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_col      (o_cursor_col),
        .o_attribute       (o_attribute),
        .o_read_cell       (o_read_cell),
        .o_scrolled        (o_scrolled),
        .o_background_next (o_background_next)
    );

endmodule

// ----- sv/tcw_checker.sv -----
module tcw_checker #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [tcw_pkg::ROW_OUT_W-1:0]    o_cursor_row,
    input logic [tcw_pkg::COL_OUT_W-1:0]    o_cursor_col,
    input logic                             o_scrolled
);
    import tcw_pkg::*;

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // o_in_ready drops after each accepted word, so no two words are taken back to back.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

    // The cursor column stays on the screen.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cursor_col) < COLS)
        else $error("cursor column beyond the screen");

    // A scroll always leaves the cursor on the bottom row.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_row == ROW_OUT_W'(ROWS - 1))
        else $error("scroll left cursor off the bottom row");

endmodule

bind text_console_writer tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);
